// ===== hdl/assert_macros.svh =====
// Assertion helpers; the module using them supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dr2s_pkg.sv =====
package dr2s_pkg;

	localparam int GRID_SIZE = 256;
	localparam int CW  = 9;                   // coordinate field width
	localparam int LW  = $clog2(GRID_SIZE);   // bits of a 0-based row/column
	localparam int IW  = LW + 2;              // walk index, reaches 2*GRID_SIZE
	localparam int AW  = 2 * LW;              // cell address
	localparam int SW  = 32;                  // sum width
	localparam int WW  = 16;                  // weight width
	localparam int PAW = 3;                   // APB address width
	localparam int RIW = PAW - 2;             // register index bits

	localparam logic [CW-1:0]  GRID_MAX       = CW'(GRID_SIZE);
	localparam logic [CW-1:0]  GRID_WIDTH_RST = CW'(256);
	localparam logic [RIW-1:0] REG_GRID_WIDTH = RIW'(0);

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ARD,
		ST_AWR,
		ST_QSTART,
		ST_QRD,
		ST_QDRAIN,
		ST_QFIN
	} seq_state_t;

	typedef struct packed {
		logic          re;
		logic          we;
		logic [AW-1:0] addr;
		logic [SW-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic idle;
		logic clearing;
		logic adding;
	} seq_status_t;

	function automatic logic [IW-1:0] low_bit(input logic [IW-1:0] v);
		return v & (~v + IW'(1));
	endfunction

	// 1-based (i, j) to flat cell address
	function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] i,
		input logic [IW-1:0] j);
		logic [IW-1:0] im;
		logic [IW-1:0] jm;
		im = i - IW'(1);
		jm = j - IW'(1);
		return {im[LW-1:0], jm[LW-1:0]};
	endfunction

endpackage

// ===== hdl/dynamic_2d_rectangle_sum_core.sv =====
// Dynamic 2-D rectangle sum over a 256 x 256 grid, kept as a 2-D Fenwick tree
// in one 64K x 32 single-port RAM (registered read).
// Input channel (item_valid / item_stall): kind 0 adds weight at (x_a, y_a),
// kind 1 asks for the sum over [x_a..x_b] x [y_a..y_b]. Adds give no result.
// Output channel (result_valid / result_stall): one rect_sum beat per query.
// Config: APB, one register grid_width at address 0, pready tied high.
// Sequencing: one item at a time. An add is a read-modify-write per tree cell,
// a read then a write. A query reads one cell per cycle over four corner
// prefixes; an empty query reads no cells. The single RAM port serializes these
// reads and writes.
// Reset: after arst_n the block sweeps all 65536 cells to zero, one per cycle,
// with item_stall high; APB writes are taken during the sweep.
// Stall: a finished result sits in the output register; the next item is
// taken meanwhile, and a later query holds its sum until that beat is taken.
`include "assert_macros.svh"

module dynamic_2d_rectangle_sum_core import dr2s_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// APB config
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PAW-1:0]       paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// item channel
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 kind,
	input  logic [CW-1:0]        x_a,
	input  logic [CW-1:0]        y_a,
	input  logic [CW-1:0]        x_b,
	input  logic [CW-1:0]        y_b,
	input  logic signed [WW-1:0] weight,
	// result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [SW-1:0] rect_sum
);

	logic [CW-1:0] grid_width_q;
	logic [CW-1:0] uw;           // usable width, capped at the grid size
	logic          cfg_wr;

	mem_req_t      mem_req;
	logic [SW-1:0] mem_rdata;
	seq_status_t   status;

	// APB register file: only grid_width; other indexes read zero, writes dropped
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RST;
		end else if (cfg_wr && paddr[PAW-1:2] == REG_GRID_WIDTH) begin
			grid_width_q <= pwdata[CW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PAW-1:2] == REG_GRID_WIDTH) begin
			prdata = {{(32-CW){1'b0}}, grid_width_q};
		end
	end

	assign uw = (grid_width_q > GRID_MAX) ? GRID_MAX : grid_width_q;

	// walk sequencer: clear sweep, add walk, query walk, result register
	dr2s_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.x_a          (x_a),
		.y_a          (y_a),
		.x_b          (x_b),
		.y_b          (y_b),
		.weight       (weight),
		.uw           (uw),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.rect_sum     (rect_sum),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.status       (status)
	);

	// tree cells
	dr2s_ram #(
		.DATA_W (SW),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	// single port: a cycle is a read or a write, never both
	`ASSERT_NEVER(a_port_conflict, mem_req.re && mem_req.we, "RAM read and write collide")
	// no item may enter while the tree is still being zeroed
	`ASSERT_IMPLIES(a_stall_in_clear, status.clearing, item_stall, "item taken during clear")
	// an idle sequencer always takes the next beat
	`ASSERT_IMPLIES(a_idle_open, status.idle, !item_stall, "input stalled while idle")
	// writes only come from the clear sweep or an add walk
	`ASSERT_IMPLIES(a_write_source, mem_req.we, status.clearing || status.adding,
		"RAM write outside clear or add")
	// the sweep writes zeros
	`ASSERT_IMPLIES(a_clear_zero, status.clearing && mem_req.we, mem_req.wdata == '0,
		"clear sweep writes nonzero")

endmodule

// ===== hdl/dr2s_ram.sv =====
module dr2s_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hdl/dr2s_seq.sv =====
module dr2s_seq import dr2s_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 kind,
	input  logic [CW-1:0]        x_a,
	input  logic [CW-1:0]        y_a,
	input  logic [CW-1:0]        x_b,
	input  logic [CW-1:0]        y_b,
	input  logic signed [WW-1:0] weight,
	input  logic [CW-1:0]        uw,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [SW-1:0] rect_sum,
	output mem_req_t             mem_req,
	input  logic [SW-1:0]        mem_rdata,
	output seq_status_t          status
);

	seq_state_t state_q, state_d;
	logic [AW-1:0] clr_q, clr_d;
	logic          rd_s1, rd_d;
	logic          sub_s1, sub_d;
	logic          result_valid_q, load_res;

	logic [CW-1:0]        xa_q, ya_q, xb_q, yb_q;
	logic signed [WW-1:0] wt_q;
	logic [IW-1:0]        i_q, i_d, j_q, j_d;
	logic [1:0]           corner_q, corner_d;
	logic [SW-1:0]        acc_q, acc_d;
	logic signed [SW-1:0] rect_sum_q;

	logic          accept;
	logic [CW-1:0] xa_r, ya_r, xb_c, yb_c;
	logic          on_grid, empty;
	logic [CW-1:0] cx, cy;
	logic [IW-1:0] j_up, i_up, j_dn, i_dn;
	logic [SW-1:0] wt_ext;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		xa_r    = (x_a == '0) ? CW'(1) : x_a;
		ya_r    = (y_a == '0) ? CW'(1) : y_a;
		xb_c    = (x_b > uw) ? uw : x_b;
		yb_c    = (y_b > uw) ? uw : y_b;
		on_grid = (x_a != '0) && (x_a <= uw) && (y_a != '0) && (y_a <= uw);
		empty   = (xa_r > xb_c) || (ya_r > yb_c);
		cx      = corner_q[0] ? (xa_q - CW'(1)) : xb_q;
		cy      = corner_q[1] ? (ya_q - CW'(1)) : yb_q;
		j_up    = j_q + low_bit(j_q);
		i_up    = i_q + low_bit(i_q);
		j_dn    = j_q - low_bit(j_q);
		i_dn    = i_q - low_bit(i_q);
		wt_ext  = {{(SW-WW){wt_q[WW-1]}}, wt_q};
	end

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		i_d      = i_q;
		j_d      = j_q;
		corner_d = corner_q;
		rd_d     = 1'b0;
		sub_d    = sub_s1;
		load_res = 1'b0;
		acc_d    = rd_s1 ? (sub_s1 ? acc_q - mem_rdata : acc_q + mem_rdata) : acc_q;
		mem_req  = '{re: 1'b0, we: 1'b0, addr: cell_addr(i_q, j_q), wdata: '0};

		case (state_q)
			ST_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
				clr_d        = clr_q + AW'(1);
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_QUERY) begin
						acc_d    = '0;
						corner_d = 2'd0;
						state_d  = empty ? ST_QFIN : ST_QSTART;
					end else if (on_grid) begin
						i_d     = IW'(xa_r);
						j_d     = IW'(ya_r);
						state_d = ST_ARD;
					end
				end
			end
			ST_ARD: begin
				mem_req.re = 1'b1;
				state_d    = ST_AWR;
			end
			ST_AWR: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = mem_rdata + wt_ext;
				state_d       = ST_ARD;
				if (j_up <= IW'(GRID_SIZE)) begin
					j_d = j_up;
				end else if (i_up <= IW'(GRID_SIZE)) begin
					i_d = i_up;
					j_d = IW'(ya_q);
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_QSTART: begin
				if (cx == '0 || cy == '0) begin
					if (corner_q == 2'd3) begin
						state_d = ST_QDRAIN;
					end else begin
						corner_d = corner_q + 2'd1;
					end
				end else begin
					i_d     = IW'(cx);
					j_d     = IW'(cy);
					state_d = ST_QRD;
				end
			end
			ST_QRD: begin
				mem_req.re = 1'b1;
				rd_d       = 1'b1;
				sub_d      = corner_q[0] ^ corner_q[1];
				if (j_dn != '0) begin
					j_d = j_dn;
				end else if (i_dn != '0) begin
					i_d = i_dn;
					j_d = IW'(cy);
				end else if (corner_q == 2'd3) begin
					state_d = ST_QDRAIN;
				end else begin
					corner_d = corner_q + 2'd1;
					state_d  = ST_QSTART;
				end
			end
			ST_QDRAIN: begin
				state_d = ST_QFIN;
			end
			ST_QFIN: begin
				if (!result_valid_q || !result_stall) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			rd_s1          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			rd_s1   <= rd_d;
			if (load_res) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xa_q <= xa_r;
			ya_q <= ya_r;
			xb_q <= xb_c;
			yb_q <= yb_c;
			wt_q <= weight;
		end
		i_q      <= i_d;
		j_q      <= j_d;
		corner_q <= corner_d;
		sub_s1   <= sub_d;
		acc_q    <= acc_d;
		if (load_res) begin
			rect_sum_q <= $signed(acc_q);
		end
	end

	assign result_valid    = result_valid_q;
	assign rect_sum        = rect_sum_q;
	assign status.idle     = (state_q == ST_IDLE);
	assign status.clearing = (state_q == ST_CLEAR);
	assign status.adding   = (state_q == ST_ARD) || (state_q == ST_AWR);

endmodule
